// ===== hdl/spdc_pkg.sv =====
package spdc_pkg;

	localparam logic [15:0] HEADER_PATTERN_RESET = 16'hFAFB;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_CK_LO   = 3'd3,
		PH_CK_HI   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_GOOD      = 2'd1,
		KIND_MISMATCH  = 2'd2,
		KIND_BAD_LEN   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic       first_of_frame;
		logic [7:0] payload_length;
	} result_t;

endpackage

// ===== hdl/spdc_core.sv =====
module spdc_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	input  logic [15:0]           header_pattern,
	output logic                  res_valid,
	output spdc_pkg::result_t     res
);
	import spdc_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  prev_q, prev_d;
	logic [7:0]  left_q, left_d;
	logic [7:0]  flen_q, flen_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  held_q, held_d;
	logic        pend_q, pend_d;
	logic [7:0]  rlo_q, rlo_d;

	logic [15:0] computed;
	logic [15:0] got;
	logic [7:0]  left_dec;

	assign computed = sum_q ^ (pend_q ? {8'd0, held_q} : 16'd0);
	assign got      = {rx_byte, rlo_q};
	assign left_dec = left_q - 8'd1;

	// next state
	always_comb begin
		phase_d = phase_q;
		prev_d  = prev_q;
		left_d  = left_q;
		flen_d  = flen_q;
		sum_d   = sum_q;
		held_d  = held_q;
		pend_d  = pend_q;
		rlo_d   = rlo_q;
		case (phase_q)
			PH_LENGTH: begin
				if (rx_byte < 8'd2) begin
					flen_d  = 8'd0;
					phase_d = PH_HUNT;
					prev_d  = 8'd0;
					left_d  = 8'd0;
					sum_d   = 16'd0;
					held_d  = 8'd0;
					pend_d  = 1'b0;
					rlo_d   = 8'd0;
				end else begin
					flen_d  = rx_byte - 8'd2;
					left_d  = rx_byte - 8'd2;
					sum_d   = 16'd0;
					held_d  = 8'd0;
					pend_d  = 1'b0;
					phase_d = (rx_byte == 8'd2) ? PH_CK_LO : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (pend_q) begin
					sum_d  = sum_q + {held_q, rx_byte};
					pend_d = 1'b0;
				end else begin
					held_d = rx_byte;
					pend_d = 1'b1;
				end
				left_d = left_dec;
				if (left_dec == 8'd0) begin
					phase_d = PH_CK_LO;
				end
			end
			PH_CK_LO: begin
				rlo_d   = rx_byte;
				phase_d = PH_CK_HI;
			end
			PH_CK_HI: begin
				phase_d = PH_HUNT;
				prev_d  = 8'd0;
				left_d  = 8'd0;
				sum_d   = 16'd0;
				held_d  = 8'd0;
				pend_d  = 1'b0;
				rlo_d   = 8'd0;
			end
			default: begin
				// unused codes hunt too
				prev_d  = rx_byte;
				phase_d = ({prev_q, rx_byte} == header_pattern) ? PH_LENGTH : PH_HUNT;
			end
		endcase
	end

	// result
	always_comb begin
		res_valid          = 1'b0;
		res.kind           = KIND_PAYLOAD;
		res.payload_byte   = 8'd0;
		res.first_of_frame = 1'b0;
		res.payload_length = 8'd0;
		case (phase_q)
			PH_LENGTH: begin
				if (rx_byte < 8'd2) begin
					res_valid = 1'b1;
					res.kind  = KIND_BAD_LEN;
				end
			end
			PH_PAYLOAD: begin
				res_valid          = 1'b1;
				res.payload_byte   = rx_byte;
				res.first_of_frame = (left_q == flen_q);
			end
			PH_CK_HI: begin
				res_valid          = 1'b1;
				res.kind           = (got == computed) ? KIND_GOOD : KIND_MISMATCH;
				res.payload_length = flen_q;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			prev_q  <= 8'd0;
			left_q  <= 8'd0;
			flen_q  <= 8'd0;
			sum_q   <= 16'd0;
			held_q  <= 8'd0;
			pend_q  <= 1'b0;
			rlo_q   <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			prev_q  <= prev_d;
			left_q  <= left_d;
			flen_q  <= flen_d;
			sum_q   <= sum_d;
			held_q  <= held_d;
			pend_q  <= pend_d;
			rlo_q   <= rlo_d;
		end
	end

`ifndef SYNTHESIS
	a_flen_range: assert property (@(posedge clk) disable iff (!arst_n)
		flen_q <= 8'd253)
		else $error("frame length out of range");

	a_ckhi_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_CK_HI |=> phase_q == PH_HUNT && !pend_q && sum_q == 16'd0)
		else $error("frame not cleared after checksum");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> left_q != 8'd0 && left_q <= flen_q)
		else $error("payload count inconsistent");

	a_first_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.first_of_frame |-> res.kind == KIND_PAYLOAD)
		else $error("first flag on status item");
`endif

endmodule

// ===== hdl/serial_packet_deframer_checksum.sv =====
// channel  | dir | tdata                                  | tuser
// s_axis   | in  | [7:0] rx_byte                          | -
// m_axis   | out | [7:0] payload_byte, [15:8] payload_len | [1:0] result_kind, [2] first_of_frame
// cfg      | in  | cfg_wr_data = header_pattern (first header byte in [15:8])
//
// One byte per cycle sustained while m_axis takes each item. An accepted byte is held
// in the input register and applied to the frame state when it can advance; at that
// edge its item is registered into the result register that drives m_axis_tvalid.
// Hunt bytes, a valid length byte and the low checksum byte give no item.
// Reset clears the frame state and loads header pattern 16'hFAFB.
// Input ready falls only while the held byte cannot move because the result
// register is full and not taken.
module serial_packet_deframer_checksum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,    // [7:0] payload_byte, [15:8] payload_length
	output logic [2:0]  m_axis_tuser     // [1:0] result_kind, [2] first_of_frame
);
	import spdc_pkg::*;

	logic [15:0] pattern_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic        advance;
	logic        res_valid;
	result_t     res;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= HEADER_PATTERN_RESET;
		end else if (cfg_wr_en) begin
			pattern_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	spdc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.rx_byte        (byte_s1),
		.header_pattern (pattern_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.payload_length, res_s2.payload_byte};
	assign m_axis_tuser  = {res_s2.first_of_frame, res_s2.kind};

endmodule

// ===== test/tb_serial_packet_deframer_checksum.sv =====
`timescale 1ns / 100ps

module tb_serial_packet_deframer_checksum;
	import spdc_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;     // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;     // [7:0] payload_byte, [15:8] payload_length
	logic [2:0]  m_axis_tuser;     // [1:0] result_kind, [2] first_of_frame

	serial_packet_deframer_checksum dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// deframer state as the testbench sees it
	logic [15:0] hdr_pattern;
	phase_t      ph;
	logic [7:0]  win_hi;
	logic [7:0]  left;
	logic [7:0]  plen;
	logic [15:0] wsum;
	logic [7:0]  hi_byte;
	logic        hi_valid;
	logic [7:0]  ck_low;

	result_t     results_due[$];
	result_t     want;
	int          errors = 0;
	int          bytes_sent = 0;
	int unsigned cycle_count = 0;
	bit          src_idle = 1'b1;
	bit          sink_idle = 1'b1;

	function automatic void note_result(kind_t k, logic [7:0] d, logic f, logic [7:0] len);
		result_t r;
		r.kind = k;
		r.payload_byte = d;
		r.first_of_frame = f;
		r.payload_length = len;
		results_due.push_back(r);
	endfunction

	function automatic void restart_hunt();
		ph = PH_HUNT;
		win_hi = '0;
		left = '0;
		wsum = '0;
		hi_byte = '0;
		hi_valid = 1'b0;
		ck_low = '0;
	endfunction

	function automatic void deframe_byte(logic [7:0] b);
		logic [15:0] calc;
		logic        first;
		case (ph)
			PH_LENGTH: begin
				if (b < 8'd2) begin
					plen = '0;
					restart_hunt();
					note_result(KIND_BAD_LEN, 8'h00, 1'b0, 8'h00);
				end else begin
					plen = b - 8'd2;
					left = plen;
					wsum = '0;
					hi_byte = '0;
					hi_valid = 1'b0;
					ph = (plen == 8'd0) ? PH_CK_LO : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				first = (left == plen);
				if (hi_valid) begin
					wsum = wsum + {hi_byte, b};
					hi_valid = 1'b0;
				end else begin
					hi_byte = b;
					hi_valid = 1'b1;
				end
				left = left - 8'd1;
				if (left == 8'd0)
					ph = PH_CK_LO;
				note_result(KIND_PAYLOAD, b, first, 8'h00);
			end
			PH_CK_LO: begin
				ck_low = b;
				ph = PH_CK_HI;
			end
			PH_CK_HI: begin
				// odd tail byte folds into the low half of the sum
				calc = wsum ^ (hi_valid ? {8'h00, hi_byte} : 16'h0000);
				note_result(({b, ck_low} == calc) ? KIND_GOOD : KIND_MISMATCH,
					8'h00, 1'b0, plen);
				restart_hunt();
			end
			default: begin
				ph = ({win_hi, b} == hdr_pattern) ? PH_LENGTH : PH_HUNT;
				win_hi = b;
			end
		endcase
	endfunction

	function automatic logic [15:0] payload_checksum(byte_q_t p);
		logic [15:0] s;
		s = '0;
		for (int i = 0; i < p.size(); i += 2) begin
			if (i + 1 < p.size())
				s = s + {p[i], p[i+1]};
			else
				s = s ^ {8'h00, p[i]};
		end
		return s;
	endfunction

	function automatic byte_q_t random_payload(int n);
		byte_q_t p;
		for (int i = 0; i < n; i++)
			p.push_back(8'($urandom_range(0, 255)));
		return p;
	endfunction

	task automatic send_byte(logic [7:0] b);
		int gap;
		if (src_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		deframe_byte(b);
	endtask

	task automatic send_frame(logic [15:0] hdr, byte_q_t p, logic [15:0] ck_flip);
		logic [15:0] ck;
		ck = payload_checksum(p) ^ ck_flip;
		send_byte(hdr[15:8]);
		send_byte(hdr[7:0]);
		send_byte(8'(p.size() + 2));
		foreach (p[i])
			send_byte(p[i]);
		send_byte(ck[7:0]);
		send_byte(ck[15:8]);
	endtask

	// lets the pipe empty out, including bytes that give no item
	task automatic settle_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_header(logic [15:0] p);
		settle_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= p;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		hdr_pattern = p;
	endtask

	task automatic random_frame(logic [15:0] hdr);
		int      pick;
		int      n;
		byte_q_t p;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 16) begin
			send_byte(hdr[15:8]);
			send_byte(hdr[7:0]);
			send_byte(8'($urandom_range(0, 1)));
		end else begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
			p = random_payload(n);
			send_frame(hdr, p, (pick < 32) ? 16'($urandom_range(1, 65535)) : 16'h0000);
		end
	endtask

	task automatic run_traffic(logic [15:0] hdr, int n_bytes, bit with_idle);
		int start;
		write_header(hdr);
		src_idle = with_idle;
		sink_idle = with_idle;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes)
			random_frame(hdr);
	endtask

	task automatic test_default_header();
		byte_q_t p;
		send_byte(8'hFA);          // false start, window slides on
		p = {8'h00, 8'hFF, 8'h80};
		send_frame(HEADER_PATTERN_RESET, p, 16'h0000);
		send_byte(8'hFA);
		send_byte(8'hFB);
		send_byte(8'h00);
		send_byte(8'hFA);
		send_byte(8'hFB);
		send_byte(8'h01);
		p = {};
		send_frame(HEADER_PATTERN_RESET, p, 16'h0000);
		p = {8'h7F, 8'h01};
		send_frame(HEADER_PATTERN_RESET, p, 16'h8001);
	endtask

	task automatic test_header_config();
		byte_q_t p;
		// zero pattern matches the cleared window on a single zero
		write_header(16'h0000);
		send_byte(8'h00);
		send_byte(8'h03);
		send_byte(8'hAA);
		send_byte(8'hAA);
		send_byte(8'h00);
		// upper byte zero: lower header byte alone is enough
		write_header(16'h00C3);
		send_byte(8'hC3);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h00);
		write_header(16'hFFFF);
		p = {8'hFF, 8'hFF};
		send_frame(16'hFFFF, p, 16'h0000);
	endtask

	task automatic test_random_traffic();
		logic [15:0] hdr;
		byte_q_t     p;
		hdr = 16'($urandom_range(0, 65535));
		run_traffic(hdr, 40, 1'b1);
		p = random_payload(253);   // longest legal frame
		send_frame(hdr, p, 16'h0000);
		run_traffic(16'hFFFF, 30, 1'b1);
		run_traffic(16'h0000, 30, 1'b1);
		run_traffic(16'($urandom_range(1, 255)), 30, 1'b1);
		run_traffic(HEADER_PATTERN_RESET, 60, 1'b0);
	endtask

	always begin
		@(negedge clk);
		if (sink_idle && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		m_axis_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (results_due.size() == 0) begin
				$error("item with no result due: tdata %0h tuser %0h", m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = results_due.pop_front();
				if (m_axis_tuser[1:0] !== want.kind) begin
					$error("result_kind expected %0d actual %0d", want.kind, m_axis_tuser[1:0]);
					errors++;
				end
				if (m_axis_tdata[7:0] !== want.payload_byte) begin
					$error("payload_byte expected %0h actual %0h",
						want.payload_byte, m_axis_tdata[7:0]);
					errors++;
				end
				if (m_axis_tuser[2] !== want.first_of_frame) begin
					$error("first_of_frame expected %0d actual %0d",
						want.first_of_frame, m_axis_tuser[2]);
					errors++;
				end
				if (m_axis_tdata[15:8] !== want.payload_length) begin
					$error("payload_length expected %0d actual %0d",
						want.payload_length, m_axis_tdata[15:8]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		hdr_pattern = HEADER_PATTERN_RESET;
		plen = '0;
		restart_hunt();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_header();
		test_header_config();
		test_random_traffic();

		settle_idle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
